@@ hw/rtl/deq_pkg.sv @@
// Package for the double-ended queue.
// Holds the command and status codes and the per-cell control struct.
// No dependencies.
package deq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_POP_BACK   = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
		logic pop_back;
		logic clr;
	} cell_ctl_t;

endpackage

@@ hw/rtl/deq_cell.sv @@
// One storage cell of the double-ended queue chain.
// Holds a word and an occupancy bit; depends on deq_pkg.
module deq_cell import deq_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] push_data,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  right_valid,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tap
);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  is_back;
	logic                  is_slot;

	assign is_back = valid_q & ~right_valid;
	assign is_slot = left_valid & ~valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.push_front) begin
			valid_q <= left_valid;
		end else if (ctl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctl.push_back && is_slot) begin
			valid_q <= 1'b1;
		end else if (ctl.pop_back && is_back) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_back && is_slot) begin
			data_q <= push_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign tap   = is_back ? data_q : '0;

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// Bounded double-ended queue built as a chain of DEPTH cells; depends on deq_pkg, deq_cell.
// Accepted commands yield a registered result in the next cycle; one transaction per cycle
// while in_stall is low, set by the shift of the cell chain and one output register.
// Reset: arst_n clears all occupancy bits, the count and the output valid; stored words
// are left as they are.
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            command,
	input  logic [DATA_WIDTH-1:0] data_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [1:0]            status,
	output logic [CW-1:0]         count
);

	logic [DEPTH-1:0]      cell_valid;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
	logic [DATA_WIDTH-1:0] back_word;

	logic                  accept;
	logic                  full;
	logic                  empty;
	cell_ctl_t             ctl;
	status_t               st_next;
	logic [DATA_WIDTH-1:0] word_next;
	logic [CW-1:0]         count_next;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	status_t               status_q;
	logic [CW-1:0]         count_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign full     = cell_valid[DEPTH-1];
	assign empty    = ~cell_valid[0];

	always_comb begin
		ctl        = '0;
		st_next    = ST_DONE;
		word_next  = '0;
		count_next = count_q;
		unique case (command)
			CMD_PUSH_BACK: begin
				if (full) begin
					st_next = ST_FULL;
				end else begin
					ctl.push_back = accept;
					count_next    = count_q + 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					st_next = ST_FULL;
				end else begin
					ctl.push_front = accept;
					count_next     = count_q + 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					st_next = ST_EMPTY;
				end else begin
					ctl.pop_back = accept;
					word_next    = back_word;
					count_next   = count_q - 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					st_next = ST_EMPTY;
				end else begin
					ctl.pop_front = accept;
					word_next     = cell_data[0];
					count_next    = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				ctl.clr    = accept;
				count_next = '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  lv;
		logic [DATA_WIDTH-1:0] ld;
		logic                  rv;
		logic [DATA_WIDTH-1:0] rd;

		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign ld = data_in;
		end else begin : g_mid_l
			assign lv = cell_valid[i-1];
			assign ld = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_mid_r
			assign rv = cell_valid[i+1];
			assign rd = cell_data[i+1];
		end

		deq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.push_data  (data_in),
			.left_valid (lv),
			.left_data  (ld),
			.right_valid(rv),
			.right_data (rd),
			.valid      (cell_valid[i]),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q <= word_next;
			status_q   <= st_next;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign count     = count_q;

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == (count_q != '0))
		else $error("front cell occupancy disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[DEPTH-1] == (count_q == CW'(DEPTH)))
		else $error("back cell occupancy disagrees with count");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && empty && (command == CMD_POP_BACK || command == CMD_POP_FRONT)
		|=> status == ST_EMPTY && data_out == '0)
		else $error("pop on empty queue not flagged");

endmodule
